### design/longest_nondecreasing_subsequence_macros.svh
// Assertion macros for the longest non-decreasing subsequence checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_MACROS_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LNS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lns_pkg.sv
// Shared types, constants and the control store for the subsequence block.
// No dependencies; used by the top level and by the checker.
package lns_pkg;

	localparam int LNS_MAX_ELEMS = 64;
	localparam int VALUE_BITS    = 16;
	localparam int LEN_W         = 7;
	localparam int STEPS_W       = 6;
	localparam int PC_W          = 4;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} lns_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] element;
		logic [STEPS_W-1:0]           insert_steps;
		logic [LEN_W-1:0]             seq_length;
		logic                         overflow;
		logic                         last_out;
	} lns_result_t;

	// Micro-operations driven into the datapath, one per step.
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LOAD,
		UOP_TEST,
		UOP_SCAN,
		UOP_STORE,
		UOP_FINIT,
		UOP_FIND,
		UOP_WINIT,
		UOP_WREAD,
		UOP_WWRITE,
		UOP_EINIT,
		UOP_EMIT,
		UOP_CLEAR
	} uop_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NO_START,
		JC_FULL,
		JC_J_END,
		JC_J_MORE,
		JC_NOT_LAST,
		JC_K_MORE,
		JC_E_MORE
	} jcond_t;

	typedef logic [PC_W-1:0] step_t;

	typedef struct packed {
		uop_t   uop;
		jcond_t cond;
		step_t  target;
	} ucw_t;

	localparam step_t S_IDLE   = 4'd0;
	localparam step_t S_TEST   = 4'd1;
	localparam step_t S_TESTZ  = 4'd2;
	localparam step_t S_SCAN   = 4'd3;
	localparam step_t S_DRAIN  = 4'd4;
	localparam step_t S_STORE  = 4'd5;
	localparam step_t S_LAST   = 4'd6;
	localparam step_t S_FINIT  = 4'd7;
	localparam step_t S_FIND   = 4'd8;
	localparam step_t S_FDRAIN = 4'd9;
	localparam step_t S_WINIT  = 4'd10;
	localparam step_t S_WREAD  = 4'd11;
	localparam step_t S_WWRITE = 4'd12;
	localparam step_t S_EINIT  = 4'd13;
	localparam step_t S_EMIT   = 4'd14;
	localparam step_t S_EDRAIN = 4'd15;

	// Control store: operation, jump condition, jump target. A jump not taken
	// falls through to the next step.
	function automatic ucw_t ucode_rom(input step_t pc);
		ucw_t w;
		unique case (pc)
			S_IDLE:   w = '{UOP_LOAD,   JC_NO_START, S_IDLE};
			S_TEST:   w = '{UOP_TEST,   JC_FULL,     S_LAST};
			S_TESTZ:  w = '{UOP_NOP,    JC_J_END,    S_DRAIN};
			S_SCAN:   w = '{UOP_SCAN,   JC_J_MORE,   S_SCAN};
			S_DRAIN:  w = '{UOP_NOP,    JC_NEVER,    S_IDLE};
			S_STORE:  w = '{UOP_STORE,  JC_NEVER,    S_IDLE};
			S_LAST:   w = '{UOP_NOP,    JC_NOT_LAST, S_IDLE};
			S_FINIT:  w = '{UOP_FINIT,  JC_NEVER,    S_IDLE};
			S_FIND:   w = '{UOP_FIND,   JC_J_MORE,   S_FIND};
			S_FDRAIN: w = '{UOP_NOP,    JC_NEVER,    S_IDLE};
			S_WINIT:  w = '{UOP_WINIT,  JC_NEVER,    S_IDLE};
			S_WREAD:  w = '{UOP_WREAD,  JC_NEVER,    S_IDLE};
			S_WWRITE: w = '{UOP_WWRITE, JC_K_MORE,   S_WREAD};
			S_EINIT:  w = '{UOP_EINIT,  JC_NEVER,    S_IDLE};
			S_EMIT:   w = '{UOP_EMIT,   JC_E_MORE,   S_EMIT};
			S_EDRAIN: w = '{UOP_CLEAR,  JC_ALWAYS,   S_IDLE};
			default:  w = '{UOP_NOP,    JC_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

endpackage

### design/longest_nondecreasing_subsequence.sv
// Top level of the longest non-decreasing subsequence block: microcoded
// sequencer and datapath. Depends on lns_pkg.
//
// Usage. An array arrives one element per transaction: a transaction is taken
// at a rising edge with start high and busy low, carrying item.value and
// item.last. For each element the block scans all stored elements (at most
// MAX_ELEMS), one per cycle, through a single read port on the value and
// length memories; an element past capacity is dropped and sets the
// overflow flag. When item.last is set the block then finds the first element
// with the greatest run length, walks the predecessor links back into a stack
// (one memory read then a write per subsequence element) and plays the stack
// out in order. Results come one per cycle with strobe high for exactly one
// cycle each; the receiver cannot stall them. The last result carries
// result.last_out, and busy drops the cycle after it.
// Reset (arst_n low) returns the sequencer to its idle step and empties the
// array; the memories hold no reset value and are only read where written.
module longest_nondecreasing_subsequence #(
	parameter int MAX_ELEMS = lns_pkg::LNS_MAX_ELEMS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lns_pkg::lns_item_t  item,
	output logic                busy,
	output logic                strobe,
	output lns_pkg::lns_result_t result
);
	import lns_pkg::*;

	localparam int IW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	// Sequencer state.
	step_t pc_q;
	step_t pc_next;
	ucw_t  ucw;
	logic  jump;

	// Datapath registers.
	logic [CW-1:0]                cnt_q;
	logic                         ovf_q;
	logic [CW-1:0]                j_q;
	logic [CW-1:0]                j_next;
	logic [LEN_W-1:0]             k_q;
	logic [LEN_W-1:0]             k_dec;
	logic [LEN_W-1:0]             best_q;
	logic [IW-1:0]                link_q;
	logic [IW-1:0]                ptr_q;
	logic signed [VALUE_BITS-1:0] cur_q;
	logic                         last_q;
	logic                         full;

	// Read pipeline stage.
	logic          scan_s1;
	logic          find_s1;
	logic          emit_s1;
	logic          last_s1;
	logic [IW-1:0] jj_s1;

	// Memories and their registered read data.
	logic signed [VALUE_BITS-1:0] val_mem_q [MAX_ELEMS];
	logic [LEN_W-1:0]             len_mem_q [MAX_ELEMS];
	logic [IW-1:0]                prd_mem_q [MAX_ELEMS];
	logic signed [VALUE_BITS-1:0] stk_mem_q [MAX_ELEMS];
	logic signed [VALUE_BITS-1:0] vrd_q;
	logic [LEN_W-1:0]             lrd_q;
	logic [IW-1:0]                prd_q;
	logic signed [VALUE_BITS-1:0] srd_q;
	logic [IW-1:0]                vaddr;

	// Compare results of the shared scan unit.
	logic             take_scan;
	logic             take_find;
	logic [LEN_W-1:0] lrd_inc;
	logic [LEN_W-1:0] steps_w;

	assign ucw    = ucode_rom(pc_q);
	assign full   = (cnt_q == CW'(MAX_ELEMS));
	assign j_next = j_q + CW'(1);
	assign k_dec  = k_q - LEN_W'(1);
	assign vaddr  = (ucw.uop == UOP_WREAD) ? ptr_q : j_q[IW-1:0];

	// Evaluate the jump condition of the current control word.
	always_comb begin
		unique case (ucw.cond)
			JC_NEVER:    jump = 1'b0;
			JC_ALWAYS:   jump = 1'b1;
			JC_NO_START: jump = !start;
			JC_FULL:     jump = full;
			JC_J_END:    jump = (j_q == cnt_q);
			JC_J_MORE:   jump = (j_next != cnt_q);
			JC_NOT_LAST: jump = !last_q;
			JC_K_MORE:   jump = (k_q != LEN_W'(1));
			JC_E_MORE:   jump = ((k_q + LEN_W'(1)) != best_q);
			default:     jump = 1'b0;
		endcase
		pc_next = jump ? ucw.target : pc_q + step_t'(1);
	end

	// Scan compare: a stored element no greater than the new one extends its
	// run; strict less-than keeps the first earlier element on a tie.
	assign lrd_inc   = lrd_q + LEN_W'(1);
	assign take_scan = scan_s1 && (cur_q >= vrd_q) && (best_q < lrd_inc);
	// Find compare: first element with the greatest run length.
	assign take_find = find_s1 && (best_q < lrd_q);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			j_q     <= '0;
			k_q     <= '0;
			best_q  <= '0;
			link_q  <= '0;
			ptr_q   <= '0;
			scan_s1 <= 1'b0;
			find_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			pc_q    <= pc_next;
			scan_s1 <= (ucw.uop == UOP_SCAN);
			find_s1 <= (ucw.uop == UOP_FIND);
			emit_s1 <= (ucw.uop == UOP_EMIT);
			unique case (ucw.uop)
				UOP_TEST: begin
					// Mark the overflow and arm the scan; a full array skips it.
					ovf_q  <= ovf_q | full;
					best_q <= LEN_W'(1);
					link_q <= '0;
					j_q    <= '0;
				end
				UOP_SCAN, UOP_FIND: begin
					j_q <= j_next;
				end
				UOP_STORE: begin
					cnt_q <= cnt_q + CW'(1);
				end
				UOP_FINIT: begin
					best_q <= '0;
					link_q <= '0;
					j_q    <= '0;
				end
				UOP_WINIT: begin
					k_q   <= best_q;
					ptr_q <= link_q;
				end
				UOP_WWRITE: begin
					// Follow the link back one element.
					ptr_q <= prd_q;
					k_q   <= k_dec;
				end
				UOP_EINIT: begin
					k_q <= '0;
				end
				UOP_EMIT: begin
					k_q <= k_q + LEN_W'(1);
				end
				UOP_CLEAR: begin
					// Drop the array; ready for the next one.
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
				end
			endcase
			// Compare results land in the cycle after the read; never in the same
			// step as an operation that loads best_q or link_q.
			if (take_scan) begin
				best_q <= lrd_inc;
				link_q <= jj_s1;
			end else if (take_find) begin
				best_q <= lrd_q;
				link_q <= jj_s1;
			end
		end
	end

	// Payload registers: held input and the read stage's tags.
	always_ff @(posedge clk) begin
		if (ucw.uop == UOP_LOAD) begin
			cur_q  <= item.value;
			last_q <= item.last;
		end
		jj_s1   <= j_q[IW-1:0];
		last_s1 <= ((k_q + LEN_W'(1)) == best_q);
	end

	// Element memories: written once per stored element, read by the scans
	// and the link walk.
	always_ff @(posedge clk) begin
		if (ucw.uop == UOP_STORE) begin
			val_mem_q[cnt_q[IW-1:0]] <= cur_q;
			len_mem_q[cnt_q[IW-1:0]] <= best_q;
			prd_mem_q[cnt_q[IW-1:0]] <= link_q;
		end
		vrd_q <= val_mem_q[vaddr];
		lrd_q <= len_mem_q[j_q[IW-1:0]];
		prd_q <= prd_mem_q[ptr_q];
	end

	// Stack memory: filled back to front by the walk, read front to back.
	always_ff @(posedge clk) begin
		if (ucw.uop == UOP_WWRITE) begin
			stk_mem_q[k_dec[IW-1:0]] <= vrd_q;
		end
		srd_q <= stk_mem_q[k_q[IW-1:0]];
	end

	assign steps_w = LEN_W'(cnt_q) - best_q;

	assign busy                = (pc_q != S_IDLE);
	assign strobe              = emit_s1;
	assign result.element      = srd_q;
	assign result.insert_steps = steps_w[STEPS_W-1:0];
	assign result.seq_length   = best_q;
	assign result.overflow     = ovf_q;
	assign result.last_out     = last_s1;

endmodule

### design/lns_checker.sv
// Port-level checker for the subsequence block, bound to its top level.
// Depends on lns_pkg and longest_nondecreasing_subsequence_macros.svh.
`include "longest_nondecreasing_subsequence_macros.svh"

module lns_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 strobe,
	input lns_pkg::lns_result_t result
);
	import lns_pkg::*;

	logic [LEN_W-1:0] total_len;

	assign total_len = LEN_W'(result.insert_steps) + result.seq_length;

	`LNS_ASSERT_NOW(a_strobe_busy, strobe, busy, "result shown while idle")
	`LNS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transaction taken but not busy")
	`LNS_ASSERT_NEXT(a_burst_contig, strobe && !result.last_out, strobe,
		"gap inside a result burst")
	`LNS_ASSERT_NEXT(a_burst_stable, strobe && !result.last_out,
		$stable(result.seq_length) && $stable(result.overflow) && $stable(total_len),
		"summary fields changed inside a burst")
	`LNS_ASSERT_NOW(a_len_range, strobe,
		result.seq_length != '0 && total_len <= LEN_W'(LNS_MAX_ELEMS),
		"length out of range")

endmodule

bind longest_nondecreasing_subsequence lns_checker u_lns_checker (.*);
